// ----- rtl/ctps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Convolution tile partition search package
// Shared word types, widths and command/status groups for the search core.
// ----------------------------------------------------------------------------
package ctps_pkg;

    localparam int DIM_W      = 9;
    localparam int CNT_W      = DIM_W + 1;
    localparam int CH_W       = 13;
    localparam int SLOT_W     = 16;
    localparam int AREA_W     = 2 * CNT_W;
    localparam int SPAN_W     = CNT_W;
    localparam int DIV_W      = 17;
    localparam int DIV_CNT_W  = 5;
    localparam int AB_W       = CH_W + SPAN_W;
    localparam int COST_W     = AB_W + SPAN_W;
    localparam int BEST_W     = 31;

    localparam logic [BEST_W-1:0] START_COST = BEST_W'(1 << 30);

    typedef struct packed {
        logic [DIM_W-1:0]  image_height;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  kernel_size;
        logic [CH_W-1:0]   channels;
        logic [SLOT_W-1:0] slots;
    } ctps_in_t;

    typedef struct packed {
        logic [DIM_W-1:0]  tile_height;
        logic [DIM_W-1:0]  tile_width;
        logic [BEST_W-1:0] best_cost;
        logic              found;
    } ctps_out_t;

    typedef enum logic [1:0] {
        SEL_B   = 2'd0,
        SEL_PER = 2'd1,
        SEL_A   = 2'd2,
        SEL_C   = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     row_init;
        logic     div_start;
        div_sel_t div_sel;
        logic     mul_ab;
        logic     mul_cost;
        logic     update;
        logic     next_tw;
        logic     next_th;
        logic     out_load;
    } ctps_cmd_t;

    typedef struct packed {
        logic th_ok;
        logic tw_ok;
        logic area_zero;
        logic area_over;
        logic div_done;
        logic out_free;
    } ctps_status_t;

endpackage
`default_nettype wire

// ----- rtl/ctps_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctps_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [ctps_pkg::DIV_W-1:0] num,
    input  wire logic [ctps_pkg::DIV_W-1:0] den,
    output logic                            done,
    output logic [ctps_pkg::DIV_W-1:0]      quo
);

    logic [ctps_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [ctps_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [ctps_pkg::DIV_W-1:0]     den_reg, den_next;
    logic [ctps_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ctps_pkg::DIV_W:0]       rem_sh;
    logic [ctps_pkg::DIV_W:0]       diff;
    logic                           ge;

    assign rem_sh = {rem_reg, quo_reg[ctps_pkg::DIV_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = ctps_pkg::DIV_CNT_W'(ctps_pkg::DIV_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[ctps_pkg::DIV_W-1:0] : rem_sh[ctps_pkg::DIV_W-1:0];
            quo_next = {quo_reg[ctps_pkg::DIV_W-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/ctps_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile search datapath
// Loop counters, cost factors, running minimum and the output register.
// ----------------------------------------------------------------------------
module ctps_datapath (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ctps_pkg::ctps_in_t      s_data,
    input  wire logic                    m_ready,
    output logic                         m_valid,
    output ctps_pkg::ctps_out_t          m_data,
    input  wire ctps_pkg::ctps_cmd_t     cmd,
    output ctps_pkg::ctps_status_t       status
);

    ctps_pkg::ctps_in_t                 in_reg;
    logic [ctps_pkg::CNT_W-1:0]         th_reg, th_next;
    logic [ctps_pkg::CNT_W-1:0]         tw_reg, tw_next;
    logic [ctps_pkg::SPAN_W-1:0]        b_reg;
    logic [ctps_pkg::SLOT_W-1:0]        per_reg;
    logic [ctps_pkg::CH_W-1:0]          a_reg;
    logic [ctps_pkg::SPAN_W-1:0]        c_reg;
    logic [ctps_pkg::AB_W-1:0]          ab_reg;
    logic [ctps_pkg::COST_W-1:0]        cost_reg;
    logic [ctps_pkg::BEST_W-1:0]        best_reg;
    logic [ctps_pkg::DIM_W-1:0]         bh_reg, bw_reg;
    logic                               hit_reg;
    ctps_pkg::div_sel_t                 sel_reg;
    ctps_pkg::ctps_out_t                m_data_reg;
    logic                               m_valid_reg, m_valid_next;

    logic [ctps_pkg::CNT_W-1:0]         ih, iw, k;
    logic [ctps_pkg::SPAN_W-1:0]        span_h, span_w, dh, dw;
    logic [ctps_pkg::SPAN_W:0]          num_b, num_c;
    logic [ctps_pkg::AREA_W-1:0]        area;
    logic [ctps_pkg::DIV_W-1:0]         num_a;
    logic [ctps_pkg::DIV_W-1:0]         div_num, div_den;
    logic [ctps_pkg::DIV_W-1:0]         div_quo;
    logic                               div_done;
    logic                               better;

    assign ih = {1'b0, in_reg.image_height};
    assign iw = {1'b0, in_reg.image_width};
    assign k  = {1'b0, in_reg.kernel_size};

    assign span_h = ih - k + 1'b1;
    assign span_w = iw - k + 1'b1;
    assign dh     = th_reg - k + 1'b1;
    assign dw     = tw_reg - k + 1'b1;
    assign num_b  = {1'b0, span_h} + {1'b0, dh} - 1'b1;
    assign num_c  = {1'b0, span_w} + {1'b0, dw} - 1'b1;
    assign area   = {{ctps_pkg::CNT_W{1'b0}}, th_reg} * {{ctps_pkg::CNT_W{1'b0}}, tw_reg};
    assign num_a  = ctps_pkg::DIV_W'(in_reg.channels) + ctps_pkg::DIV_W'(per_reg) - 1'b1;
    assign better = (cost_reg < ctps_pkg::COST_W'(best_reg));

    always_comb begin
        unique case (cmd.div_sel)
            ctps_pkg::SEL_B: begin
                div_num = ctps_pkg::DIV_W'(num_b);
                div_den = ctps_pkg::DIV_W'(dh);
            end
            ctps_pkg::SEL_PER: begin
                div_num = ctps_pkg::DIV_W'(in_reg.slots);
                div_den = ctps_pkg::DIV_W'(area[ctps_pkg::SLOT_W-1:0]);
            end
            ctps_pkg::SEL_A: begin
                div_num = num_a;
                div_den = ctps_pkg::DIV_W'(per_reg);
            end
            ctps_pkg::SEL_C: begin
                div_num = ctps_pkg::DIV_W'(num_c);
                div_den = ctps_pkg::DIV_W'(dw);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    ctps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        th_next = th_reg;
        tw_next = tw_reg;
        if (cmd.load) begin
            th_next = {1'b0, s_data.kernel_size};
        end else if (cmd.next_th) begin
            th_next = th_reg + 1'b1;
        end
        if (cmd.row_init) begin
            tw_next = k;
        end else if (cmd.next_tw) begin
            tw_next = tw_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sel_reg     <= ctps_pkg::SEL_B;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.div_start) begin
                sel_reg <= cmd.div_sel;
            end
        end
        th_reg <= th_next;
        tw_reg <= tw_next;
        if (cmd.load) begin
            in_reg   <= s_data;
            best_reg <= ctps_pkg::START_COST;
            bh_reg   <= s_data.image_height;
            bw_reg   <= s_data.image_width;
            hit_reg  <= 1'b0;
        end else if (cmd.update && better) begin
            best_reg <= cost_reg[ctps_pkg::BEST_W-1:0];
            bh_reg   <= th_reg[ctps_pkg::DIM_W-1:0];
            bw_reg   <= tw_reg[ctps_pkg::DIM_W-1:0];
            hit_reg  <= 1'b1;
        end
        if (div_done) begin
            unique case (sel_reg)
                ctps_pkg::SEL_B:   b_reg   <= div_quo[ctps_pkg::SPAN_W-1:0];
                ctps_pkg::SEL_PER: per_reg <= div_quo[ctps_pkg::SLOT_W-1:0];
                ctps_pkg::SEL_A:   a_reg   <= div_quo[ctps_pkg::CH_W-1:0];
                ctps_pkg::SEL_C:   c_reg   <= div_quo[ctps_pkg::SPAN_W-1:0];
                default:           b_reg   <= b_reg;
            endcase
        end
        if (cmd.mul_ab) begin
            ab_reg <= ctps_pkg::AB_W'(a_reg) * ctps_pkg::AB_W'(b_reg);
        end
        if (cmd.mul_cost) begin
            cost_reg <= ctps_pkg::COST_W'(ab_reg) * ctps_pkg::COST_W'(c_reg);
        end
        if (cmd.out_load) begin
            m_data_reg.tile_height <= bh_reg;
            m_data_reg.tile_width  <= bw_reg;
            m_data_reg.best_cost   <= best_reg;
            m_data_reg.found       <= hit_reg;
        end
    end

    assign status.th_ok     = (th_reg <= ih);
    assign status.tw_ok     = (tw_reg <= iw);
    assign status.area_zero = (area == '0);
    assign status.area_over = (area > ctps_pkg::AREA_W'(in_reg.slots));
    assign status.div_done  = div_done;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/ctps_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile search controller
// Sequences the row and column sweep and the divider and multiplier steps.
// ----------------------------------------------------------------------------
module ctps_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire ctps_pkg::ctps_status_t  status,
    output ctps_pkg::ctps_cmd_t          cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_ROW      = 13'b0000000000010,
        S_WAIT_B   = 13'b0000000000100,
        S_CAND     = 13'b0000000001000,
        S_WAIT_PER = 13'b0000000010000,
        S_START_A  = 13'b0000000100000,
        S_WAIT_A   = 13'b0000001000000,
        S_START_C  = 13'b0000010000000,
        S_WAIT_C   = 13'b0000100000000,
        S_MUL_AB   = 13'b0001000000000,
        S_MUL_COST = 13'b0010000000000,
        S_CMP      = 13'b0100000000000,
        S_FINISH   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = ctps_pkg::SEL_B;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                if (status.th_ok) begin
                    cmd.row_init  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ctps_pkg::SEL_B;
                    state_next    = S_WAIT_B;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_WAIT_B: begin
                if (status.div_done) begin
                    state_next = S_CAND;
                end
            end
            S_CAND: begin
                priority if (!status.tw_ok || status.area_over) begin
                    cmd.next_th = 1'b1;
                    state_next  = S_ROW;
                end else if (status.area_zero) begin
                    cmd.next_tw = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ctps_pkg::SEL_PER;
                    state_next    = S_WAIT_PER;
                end
            end
            S_WAIT_PER: begin
                if (status.div_done) begin
                    state_next = S_START_A;
                end
            end
            S_START_A: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ctps_pkg::SEL_A;
                state_next    = S_WAIT_A;
            end
            S_WAIT_A: begin
                if (status.div_done) begin
                    state_next = S_START_C;
                end
            end
            S_START_C: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ctps_pkg::SEL_C;
                state_next    = S_WAIT_C;
            end
            S_WAIT_C: begin
                if (status.div_done) begin
                    state_next = S_MUL_AB;
                end
            end
            S_MUL_AB: begin
                cmd.mul_ab = 1'b1;
                state_next = S_MUL_COST;
            end
            S_MUL_COST: begin
                cmd.mul_cost = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP: begin
                cmd.update  = 1'b1;
                cmd.next_tw = 1'b1;
                state_next  = S_CAND;
            end
            S_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/conv_tile_partition_search_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Convolution tile partition search core
// Searches tile sizes for the cheapest partition of one convolution.
// ----------------------------------------------------------------------------
// The input channel takes one request word with the image size, kernel side,
// channel count and slot count. The result channel returns one word with the
// chosen tile size, its cost and a found flag.
// One request is processed at a time; s_ready is high only while idle.
// Each tile row starts with a divider pass for its height factor. Each tested
// tile makes three passes through the shared serial divider, which yields a
// 17-bit quotient, then two multiply steps and a compare. Tiles of zero area
// are skipped, and a row ends at its first tile that exceeds the slot count.
// The result sits in an output register; if the receiver stalls it is held,
// and the core finishes its next search and then waits for that register.
// Reset clears the controller, the divider control and the output valid.
// ----------------------------------------------------------------------------
module conv_tile_partition_search_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ctps_pkg::ctps_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ctps_pkg::ctps_out_t       m_data
);

    ctps_pkg::ctps_cmd_t    cmd;
    ctps_pkg::ctps_status_t status;

    ctps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ctps_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

    a_found_matches_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.found == (m_data.best_cost != ctps_pkg::START_COST)))
        else $error("found flag disagrees with best cost");

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new word accepted while a search is running");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten while still held");

endmodule
`default_nettype wire
